/* src/i2cs_pkg.sv */
package i2cs_pkg;

  localparam logic [7:0] HOLD_RESET = 8'd10;
  localparam logic [7:0] RX_MSB     = 8'h80;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] tx_data;
    logic       ack_level;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       op_done;
    logic       cmd_rejected;
    logic [7:0] rx_data;
    logic       ack_seen;
  } res_t;

endpackage

/* src/i2cs_front.sv */
module i2cs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [2:0]     cmd_i,
  input  logic [7:0]     tx_data_i,
  input  logic           ack_level_i,
  input  logic           sda_sample_i,
  output logic           item_valid_o,
  output i2cs_pkg::item_t item_o,
  input  logic           item_take_i
);
  import i2cs_pkg::*;

  item_t      mem_q [2];
  item_t      item_in;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       do_push, do_pop;

  // code 7 and code 0 are plain ticks
  always_comb begin
    item_in.tx_data    = tx_data_i;
    item_in.ack_level  = ack_level_i;
    item_in.sda_sample = sda_sample_i;
    unique case (cmd_i)
      OP_START: item_in.op = OP_START;
      OP_STOP:  item_in.op = OP_STOP;
      OP_WRITE: item_in.op = OP_WRITE;
      OP_READ:  item_in.op = OP_READ;
      OP_SACK:  item_in.op = OP_SACK;
      OP_RACK:  item_in.op = OP_RACK;
      default:  item_in.op = OP_NONE;
    endcase
  end

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_take_i && item_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_in;
    end
  end

  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_i |-> item_valid_o)
    else $error("item taken from empty front queue");

endmodule

/* src/i2cs_engine.sv */
module i2cs_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            item_valid_i,
  input  i2cs_pkg::item_t item_i,
  output logic            item_take_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output i2cs_pkg::res_t  res_o
);
  import i2cs_pkg::*;

  op_e        op_q, op_d, ap_op;
  logic [4:0] step_q, step_d, ap_idx, rd_idx;
  logic [7:0] hold_q, hold_d, hold_dec, hold_cfg_q, hold_len;
  logic [7:0] shift_q, shift_d, rx_q, rx_d;
  logic       scl_q, scl_d, sda_q, sda_d, ack_q, ack_d;
  logic       done, rej, ap_en, take;

  function automatic logic [2:0] div3_q(input logic [4:0] v);
    logic [8:0] p;
    p = {4'd0, v} * 9'd11;
    return p[7:5];
  endfunction

  function automatic logic [1:0] div3_r(input logic [4:0] v);
    logic [8:0] p;
    logic [4:0] r;
    p = {4'd0, v} * 9'd11;
    r = v - ({1'b0, p[8:5]} + {p[8:5], 1'b0});
    return r[1:0];
  endfunction

  function automatic logic [4:0] last_step(input op_e op);
    unique case (op)
      OP_START: return 5'd3;
      OP_STOP:  return 5'd2;
      OP_WRITE: return 5'd23;
      OP_READ:  return 5'd24;
      OP_SACK:  return 5'd2;
      OP_RACK:  return 5'd3;
      default:  return 5'd0;
    endcase
  endfunction

  assign take        = item_valid_i && !res_full_i;
  assign item_take_o = take;
  assign res_push_o  = take;
  assign hold_len    = (hold_cfg_q == 8'd0) ? 8'd1 : hold_cfg_q;
  assign rd_idx      = ap_idx - 5'd1;

  always_comb begin
    op_d     = op_q;
    step_d   = step_q;
    hold_d   = hold_q;
    shift_d  = shift_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ack_d    = ack_q;
    rx_d     = rx_q;
    done     = 1'b0;
    rej      = 1'b0;
    ap_en    = 1'b0;
    ap_op    = op_q;
    ap_idx   = step_q;
    hold_dec = (hold_q != 8'd0) ? hold_q - 8'd1 : hold_q;
    if (take) begin
      if (op_q != OP_NONE) begin
        rej    = (item_i.op != OP_NONE);
        hold_d = hold_dec;
        if (hold_dec == 8'd0) begin
          if (step_q >= last_step(op_q)) begin
            done = 1'b1;
            if (op_q == OP_READ) begin
              rx_d = shift_q;
            end
            op_d   = OP_NONE;
            step_d = 5'd0;
          end else begin
            step_d = step_q + 5'd1;
            ap_en  = 1'b1;
            ap_idx = step_q + 5'd1;
            hold_d = hold_len;
          end
        end
      end else if (item_i.op != OP_NONE) begin
        op_d   = item_i.op;
        step_d = 5'd0;
        ap_en  = 1'b1;
        ap_op  = item_i.op;
        ap_idx = 5'd0;
        hold_d = hold_len;
        case (item_i.op)
          OP_WRITE: shift_d = item_i.tx_data;
          OP_READ:  shift_d = 8'd0;
          OP_SACK:  shift_d = {7'd0, item_i.ack_level};
          default:  ;
        endcase
      end
      if (ap_en) begin
        unique case (ap_op)
          OP_START: begin
            if (ap_idx == 5'd0) sda_d = 1'b1;
            else if (ap_idx == 5'd1) scl_d = 1'b1;
            else if (ap_idx == 5'd2) sda_d = 1'b0;
            else scl_d = 1'b0;
          end
          OP_STOP: begin
            if (ap_idx == 5'd0) sda_d = 1'b0;
            else if (ap_idx == 5'd1) scl_d = 1'b1;
            else sda_d = 1'b1;
          end
          OP_WRITE: begin
            if (div3_r(ap_idx) == 2'd0) sda_d = shift_d[3'd7 - div3_q(ap_idx)];
            else if (div3_r(ap_idx) == 2'd1) scl_d = 1'b1;
            else scl_d = 1'b0;
          end
          OP_READ: begin
            if (ap_idx == 5'd0) begin
              sda_d = 1'b1;
            end else if (div3_r(rd_idx) == 2'd0) begin
              scl_d = 1'b1;
            end else if (div3_r(rd_idx) == 2'd1) begin
              if (item_i.sda_sample) begin
                shift_d = shift_d | (RX_MSB >> div3_q(rd_idx));
              end
            end else begin
              scl_d = 1'b0;
            end
          end
          OP_SACK: begin
            if (ap_idx == 5'd0) sda_d = shift_d[0];
            else if (ap_idx == 5'd1) scl_d = 1'b1;
            else scl_d = 1'b0;
          end
          OP_RACK: begin
            if (ap_idx == 5'd0) sda_d = 1'b1;
            else if (ap_idx == 5'd1) scl_d = 1'b1;
            else if (ap_idx == 5'd2) ack_d = item_i.sda_sample;
            else scl_d = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res_o.scl_level    = scl_d;
    res_o.sda_level    = sda_d;
    res_o.busy_res     = (op_d != OP_NONE);
    res_o.op_done      = done;
    res_o.cmd_rejected = rej;
    res_o.rx_data      = rx_d;
    res_o.ack_seen     = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= OP_NONE;
      step_q     <= 5'd0;
      hold_q     <= 8'd0;
      shift_q    <= 8'd0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      ack_q      <= 1'b1;
      rx_q       <= 8'd0;
      hold_cfg_q <= HOLD_RESET;
    end else begin
      op_q    <= op_d;
      step_q  <= step_d;
      hold_q  <= hold_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      rx_q    <= rx_d;
      if (cfg_we_i) begin
        hold_cfg_q <= cfg_data_i;
      end
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.op_done |-> !res_o.busy_res)
    else $error("done reported while still busy");

  a_hold_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_q != OP_NONE |-> hold_q != 8'd0)
    else $error("active operation with empty hold counter");

  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.cmd_rejected |-> op_q != OP_NONE)
    else $error("command rejected while idle");

endmodule

/* src/i2cs_outq.sv */
module i2cs_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_push_i,
  input  i2cs_pkg::res_t res_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output i2cs_pkg::res_t res_o
);
  import i2cs_pkg::*;

  res_t       mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = mem_q[rd_q];
  assign do_push = res_push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= res_i;
    end
  end

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_i |-> !full_o)
    else $error("result pushed into full output queue");

endmodule

/* src/i2c_master_bit_sequencer.sv */
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+----------------------------------------
// item in  | push / full                 | cmd_i, tx_data_i, ack_level_i, sda_sample_i
// result   | empty / pop                 | scl_level_o .. ack_seen_o
// config   | cfg_valid_i / cfg_ready_o   | hold_ticks_i
//
// One item per cycle sustained while neither side stalls; each item yields one result.
// From push to empty low, an item passes through the front queue, then the engine into the output queue.
// The engine updates the line state once per item.
// Either side may stall; two-entry queues on each side absorb it.
// Reset: idle, lines released, hold_ticks 10, rx_data 0, ack_seen 1.
module i2c_master_bit_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] cmd_i,
  input  logic [7:0] tx_data_i,
  input  logic       ack_level_i,
  input  logic       sda_sample_i,
  output logic       empty,
  input  logic       pop,
  output logic       scl_level_o,
  output logic       sda_level_o,
  output logic       busy_res_o,
  output logic       op_done_o,
  output logic       cmd_rejected_o,
  output logic [7:0] rx_data_o,
  output logic       ack_seen_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] hold_ticks_i
);
  import i2cs_pkg::*;

  item_t item;
  res_t  res_in, res_out;
  logic  item_valid, item_take, res_push, res_full;

  assign cfg_ready_o = 1'b1;

  i2cs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .cmd_i        (cmd_i),
    .tx_data_i    (tx_data_i),
    .ack_level_i  (ack_level_i),
    .sda_sample_i (sda_sample_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  i2cs_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (hold_ticks_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  i2cs_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .full_o     (res_full),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res_out)
  );

  assign scl_level_o    = res_out.scl_level;
  assign sda_level_o    = res_out.sda_level;
  assign busy_res_o     = res_out.busy_res;
  assign op_done_o      = res_out.op_done;
  assign cmd_rejected_o = res_out.cmd_rejected;
  assign rx_data_o      = res_out.rx_data;
  assign ack_seen_o     = res_out.ack_seen;

endmodule
